@@ rtl/core/msdc_pkg.sv @@
// Shared types, operation codes and glyph tables for the segment display controller.
// Used by every module in rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package msdc_pkg;

    localparam int NUM_W      = 32;
    localparam int DIV_STEP_W = $clog2(NUM_W);

    localparam logic [2:0] OP_SCAN   = 3'd0;
    localparam logic [2:0] OP_TIME   = 3'd1;
    localparam logic [2:0] OP_NUMBER = 3'd2;
    localparam logic [2:0] OP_TEXT   = 3'd3;
    localparam logic [2:0] OP_DOT    = 3'd4;
    localparam logic [2:0] OP_RESUME = 3'd5;

    localparam logic CFG_BRIGHTNESS = 1'b0;
    localparam logic CFG_DOT_EN     = 1'b1;

    localparam logic [6:0] BRIGHT_MAX   = 7'd100;
    localparam logic [6:0] BRIGHT_RESET = 7'd100;
    localparam logic [7:0] MINUS_GLYPH  = 8'h02;
    localparam logic [7:0] DOT_BIT      = 8'h80;
    localparam logic [7:0] RESET_INDEX  = 8'd8;
    localparam logic [7:0] RESET_LAST   = 8'd0;
    localparam logic [4:0] DEC_BASE     = 5'd10;
    localparam int         DOT_DIGIT    = 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NUM_CHECK,
        ST_NUM_DIV,
        ST_TEXT
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic zero;
    } t_div_stat;

    typedef struct packed {
        logic load;
        logic raw;
        logic dot;
    } t_scan_ctl;

    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        logic [7:0] g;
        unique case (d)
            4'd0:    g = 8'h7B;
            4'd1:    g = 8'h03;
            4'd2:    g = 8'h5E;
            4'd3:    g = 8'h4F;
            4'd4:    g = 8'h27;
            4'd5:    g = 8'h6D;
            4'd6:    g = 8'h7D;
            4'd7:    g = 8'h43;
            4'd8:    g = 8'h7F;
            4'd9:    g = 8'h6F;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

    // Lower case is folded to upper case; anything without a glyph is blank.
    function automatic logic [7:0] ascii_glyph(input logic [7:0] ch);
        logic [7:0] c;
        logic [7:0] g;
        c = ch;
        if (c >= "a" && c <= "z") begin
            c = c - 8'd32;
        end
        unique case (c)
            "0":     g = 8'h7B;
            "1":     g = 8'h03;
            "2":     g = 8'h5E;
            "3":     g = 8'h4F;
            "4":     g = 8'h27;
            "5":     g = 8'h6D;
            "6":     g = 8'h7D;
            "7":     g = 8'h43;
            "8":     g = 8'h7F;
            "9":     g = 8'h6F;
            "A":     g = 8'h77;
            "B":     g = 8'h3D;
            "C":     g = 8'h79;
            "D":     g = 8'h1F;
            "E":     g = 8'h7D;
            "F":     g = 8'h75;
            "G":     g = 8'h7B;
            "H":     g = 8'h37;
            "I":     g = 8'h06;
            "J":     g = 8'h1E;
            "K":     g = 8'h76;
            "L":     g = 8'h39;
            "M":     g = 8'h54;
            "N":     g = 8'h37;
            "O":     g = 8'h3F;
            "P":     g = 8'h73;
            "Q":     g = 8'h67;
            "R":     g = 8'h31;
            "S":     g = 8'h6D;
            "T":     g = 8'h3C;
            "U":     g = 8'h3E;
            "V":     g = 8'h1E;
            "W":     g = 8'h2A;
            "X":     g = 8'h36;
            "Y":     g = 8'h2F;
            "Z":     g = 8'h5A;
            "-":     g = 8'h02;
            "_":     g = 8'h08;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

    // Quotient by ten through a reciprocal multiply, exact for every 7-bit input value.
    function automatic logic [3:0] tens_of(input logic [6:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd205;
        return 4'(p >> 11);
    endfunction

endpackage

@@ rtl/core/msdc_div10.sv @@
// Bit-serial divide-by-ten unit: one dividend bit per cycle, quotient shifted back in.
// Depends on msdc_pkg.
`timescale 1ns / 1ps

module msdc_div10
    import msdc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_ctl         i_ctl,
    input  logic [NUM_W-1:0] i_value,
    output t_div_stat        o_stat,
    output logic [3:0]       o_rem
);

    logic [NUM_W-1:0]      r_acc;
    logic [3:0]            r_rem;
    logic [DIV_STEP_W-1:0] r_bit;
    logic                  r_busy;

    logic [4:0] w_trial;
    logic       w_ge;
    logic [3:0] w_rem_next;

    assign w_trial    = {r_rem, r_acc[NUM_W-1]};
    assign w_ge       = (w_trial >= DEC_BASE);
    assign w_rem_next = w_ge ? 4'(w_trial - DEC_BASE) : w_trial[3:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_bit  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_bit  <= '0;
        end else if (r_busy) begin
            r_bit <= r_bit + 1'b1;
            if (r_bit == '1) begin
                r_busy <= 1'b0;
            end
        end
    end

    // The accumulator holds the dividend and collects the quotient in place.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_acc <= i_value;
        end else if (i_ctl.start) begin
            r_rem <= '0;
        end else if (r_busy) begin
            r_acc <= {r_acc[NUM_W-2:0], w_ge};
            r_rem <= w_rem_next;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.zero = (r_acc == '0);
    assign o_rem       = r_rem;

endmodule

@@ rtl/core/msdc_scan_out.sv @@
// Scan result stage: segment decode, dot insert, on-time scaling and the output register.
// Depends on msdc_pkg.
`timescale 1ns / 1ps

module msdc_scan_out
    import msdc_pkg::*;
#(
    parameter int POS_W = 2
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_scan_ctl        i_ctl,
    input  logic [POS_W-1:0] i_pos,
    input  logic [7:0]       i_stored,
    input  logic [6:0]       i_brightness,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [3:0]       o_digit_select,
    output logic [7:0]       o_segments,
    output logic [10:0]      o_on_time_us
);

    logic        r_valid;
    logic [3:0]  r_sel;
    logic [7:0]  r_seg;
    logic [10:0] r_on;

    logic [7:0]  w_seg;
    logic [6:0]  w_lit;
    logic [10:0] w_on;
    logic [3:0]  w_sel;

    always_comb begin
        if (i_ctl.raw) begin
            w_seg = i_stored;
        end else begin
            w_seg = (i_stored < 8'd10) ? digit_glyph(i_stored[3:0]) : 8'h00;
        end
        if (i_ctl.dot) begin
            w_seg = w_seg | DOT_BIT;
        end
    end

    // Full on-time is 2000 us at 100 percent, so each percent is 20 us.
    assign w_lit = (i_brightness > BRIGHT_MAX) ? BRIGHT_MAX : i_brightness;
    assign w_on  = {w_lit, 4'b0000} + {2'b00, w_lit, 2'b00};
    assign w_sel = (32'(i_pos) < 32'd4) ? (4'b0001 << i_pos) : 4'b0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_sel <= w_sel;
            r_seg <= w_seg;
            r_on  <= w_on;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_digit_select = r_sel;
    assign o_segments     = r_seg;
    assign o_on_time_us   = r_on;

endmodule

@@ rtl/core/multiplexed_segment_display_controller_top.sv @@
// Top level: a scan tick or set time is handled on acceptance; its result is registered the next cycle.
// Show text writes one character per cycle through a byte shift register, one per digit.
// Show number converts one decimal digit per pass of the bit-serial divide-by-ten unit,
// with a check state between passes; small values finish sooner.
// Reset is synchronous and active low; it restores the store, brightness and all modes.
// Depends on msdc_pkg, msdc_div10 and msdc_scan_out.
`timescale 1ns / 1ps

module multiplexed_segment_display_controller_top
    import msdc_pkg::*;
#(
    parameter int DIGITS = 4
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_op,
    input  logic [4:0]         i_hour,
    input  logic [5:0]         i_minute,
    input  logic signed [31:0] i_number,
    input  logic [31:0]        i_text_chars,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [3:0]         o_digit_select,
    output logic [7:0]         o_segments,
    output logic [10:0]        o_on_time_us,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [6:0]         i_cfg_wdata
);

    localparam int IW         = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int CW         = $clog2(DIGITS + 1);
    localparam int TimeDigits = (DIGITS < 4) ? DIGITS : 4;
    localparam logic [IW-1:0] LastIdx   = IW'(DIGITS - 1);
    localparam logic [IW-1:0] DotIdx    = IW'(DOT_DIGIT);
    localparam logic [CW-1:0] DigitsCnt = CW'(DIGITS);

    t_state r_state, n_state;

    logic [7:0]       r_store [DIGITS];
    logic [7:0]       n_store [DIGITS];
    logic [IW-1:0]    r_scan, n_scan;
    logic             r_raw, n_raw;
    logic             r_dot, n_dot;
    logic [6:0]       r_bright, n_bright;
    logic             r_dot_en, n_dot_en;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_neg, n_neg;
    logic [NUM_W-1:0] r_text, n_text;
    logic [IW-1:0]    r_tpos, n_tpos;
    logic             r_ended, n_ended;

    logic             w_accept;
    logic             w_num_stop;
    logic [IW-1:0]    w_num_idx;
    logic [NUM_W-1:0] w_num_bits;
    logic [NUM_W-1:0] w_mag;
    logic             w_text_end;
    logic [7:0]       w_text_glyph;
    logic [7:0]       w_time_dig [4];
    logic [3:0]       w_hour_tens;
    logic [3:0]       w_min_tens;

    t_div_ctl   div_ctl;
    t_div_stat  div_stat;
    logic [3:0] div_rem;
    t_scan_ctl  scan_ctl;

    // Non-scan requests never produce a result, so they need no room at the output.
    assign o_in_ready = (r_state == ST_IDLE)
                        && ((i_op != OP_SCAN) || !o_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    // Conversion ends when the quotient runs out (after at least one digit) or the
    // display is full.
    assign w_num_stop = (div_stat.zero && (r_cnt != '0)) || (r_cnt == DigitsCnt);
    assign w_num_idx  = LastIdx - r_cnt[IW-1:0];
    assign w_num_bits = i_number;
    assign w_mag      = w_num_bits[NUM_W-1] ? (~w_num_bits + 1'b1) : w_num_bits;

    assign w_text_end   = r_ended || (r_text[7:0] == 8'h00);
    assign w_text_glyph = w_text_end ? 8'h00 : ascii_glyph(r_text[7:0]);

    assign w_hour_tens   = tens_of(7'(i_hour));
    assign w_min_tens    = tens_of(7'(i_minute));
    assign w_time_dig[0] = 8'(w_hour_tens);
    assign w_time_dig[1] = 8'(7'(i_hour) - 7'(w_hour_tens) * 7'd10);
    assign w_time_dig[2] = 8'(w_min_tens);
    assign w_time_dig[3] = 8'(7'(i_minute) - 7'(w_min_tens) * 7'd10);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && i_op == OP_NUMBER) begin
                    n_state = ST_NUM_CHECK;
                end else if (w_accept && i_op == OP_TEXT) begin
                    n_state = ST_TEXT;
                end
            end
            ST_NUM_CHECK: begin
                n_state = w_num_stop ? ST_IDLE : ST_NUM_DIV;
            end
            ST_NUM_DIV: begin
                if (!div_stat.busy) begin
                    n_state = ST_NUM_CHECK;
                end
            end
            ST_TEXT: begin
                if (r_tpos == LastIdx) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        div_ctl.load   = 1'b0;
        div_ctl.start  = 1'b0;
        scan_ctl.load  = 1'b0;
        scan_ctl.raw   = r_raw;
        scan_ctl.dot   = r_dot && (r_scan == DotIdx);
        unique case (r_state)
            ST_IDLE: begin
                div_ctl.load  = w_accept && (i_op == OP_NUMBER);
                scan_ctl.load = w_accept && (i_op == OP_SCAN);
            end
            ST_NUM_CHECK: begin
                div_ctl.start = !w_num_stop;
            end
            ST_NUM_DIV, ST_TEXT: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_store  = r_store;
        n_scan   = r_scan;
        n_raw    = r_raw;
        n_dot    = r_dot;
        n_bright = r_bright;
        n_dot_en = r_dot_en;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        n_text   = r_text;
        n_tpos   = r_tpos;
        n_ended  = r_ended;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_op)
                        OP_SCAN: begin
                            n_scan = (r_scan == LastIdx) ? '0 : r_scan + 1'b1;
                        end
                        OP_TIME: begin
                            if (!r_raw) begin
                                for (int i = 0; i < TimeDigits; i++) begin
                                    n_store[i] = w_time_dig[i];
                                end
                            end
                        end
                        OP_NUMBER: begin
                            n_raw = 1'b1;
                            for (int i = 0; i < DIGITS; i++) begin
                                n_store[i] = 8'h00;
                            end
                            n_cnt = '0;
                            n_neg = w_num_bits[NUM_W-1];
                        end
                        OP_TEXT: begin
                            n_raw   = 1'b1;
                            n_text  = i_text_chars;
                            n_tpos  = '0;
                            n_ended = 1'b0;
                        end
                        OP_DOT: begin
                            n_dot = r_dot_en ? !r_dot : 1'b0;
                        end
                        OP_RESUME: begin
                            n_raw = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_NUM_CHECK: begin
                // The minus sign goes just left of the last digit, if a place is left.
                if (w_num_stop && r_neg && (r_cnt != DigitsCnt)) begin
                    n_store[w_num_idx] = MINUS_GLYPH;
                end
            end
            ST_NUM_DIV: begin
                if (!div_stat.busy) begin
                    n_store[w_num_idx] = digit_glyph(div_rem);
                    n_cnt              = r_cnt + 1'b1;
                end
            end
            ST_TEXT: begin
                n_store[r_tpos] = w_text_glyph;
                n_ended         = w_text_end;
                n_text          = r_text >> 8;
                n_tpos          = r_tpos + 1'b1;
            end
            default: begin
            end
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BRIGHTNESS: n_bright = i_cfg_wdata;
                CFG_DOT_EN: begin
                    n_dot_en = i_cfg_wdata[0];
                    if (!i_cfg_wdata[0]) begin
                        n_dot = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            for (int i = 0; i < DIGITS; i++) begin
                r_store[i] <= (i == DIGITS - 1) ? RESET_LAST : RESET_INDEX;
            end
            r_scan   <= '0;
            r_raw    <= 1'b0;
            r_dot    <= 1'b0;
            r_bright <= BRIGHT_RESET;
            r_dot_en <= 1'b0;
            r_cnt    <= '0;
            r_neg    <= 1'b0;
            r_tpos   <= '0;
            r_ended  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_store  <= n_store;
            r_scan   <= n_scan;
            r_raw    <= n_raw;
            r_dot    <= n_dot;
            r_bright <= n_bright;
            r_dot_en <= n_dot_en;
            r_cnt    <= n_cnt;
            r_neg    <= n_neg;
            r_tpos   <= n_tpos;
            r_ended  <= n_ended;
        end
    end

    always_ff @(posedge i_clk) begin
        r_text <= n_text;
    end

    msdc_div10 u_div10 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_value (w_mag),
        .o_stat  (div_stat),
        .o_rem   (div_rem)
    );

    msdc_scan_out #(
        .POS_W (IW)
    ) u_scan_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (scan_ctl),
        .i_pos          (r_scan),
        .i_stored       (r_store[r_scan]),
        .i_brightness   (r_bright),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_digit_select (o_digit_select),
        .o_segments     (o_segments),
        .o_on_time_us   (o_on_time_us)
    );

    a_dot_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_dot_en |-> !r_dot)
        else $error("dot flag set while blinking is disabled");

    a_result_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_accept && (i_op == OP_SCAN)))
        else $error("result appeared without an accepted scan request");

    a_div_in_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> (r_state == ST_NUM_DIV))
        else $error("divider running outside number conversion");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NUM_DIV) |-> (r_cnt < DigitsCnt))
        else $error("number conversion past the last digit");

endmodule
